/* rtl/nivs_pkg.sv */
package nivs_pkg;

  localparam int MAX_VARS_DEF = 32;

  localparam int NAME_W  = 8;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 3;
  localparam int ERR_W   = 2;

  // Slave tdata: req_type, name_a, name_b, name_c, operand_value, zero fill.
  localparam int S_DATA_W = 64;
  // Master tdata: read_value, is_zero, error_code, zero fill.
  localparam int M_DATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_DEFINE = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_READ   = 3'd3,
    OP_EQ     = 3'd4,
    OP_GT     = 3'd5,
    OP_LT     = 3'd6,
    OP_NE     = 3'd7
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK      = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_FULL    = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ENC,
    S_RDB,
    S_EXEC,
    S_FIN
  } state_t;

endpackage

/* rtl/named_int_variable_store.sv */
// Integer variable store for a small bytecode machine.
// Input transfers arrive on the s_ group, one decoded operation each: define,
// add, subtract, read, or a signed compare (eq, gt, lt, ne) whose 0/1 result
// is written to the variable named by name_c. Every operation returns exactly
// one result transfer on the m_ group: the read value, a zero flag and an
// error code (unknown name, table full).
// Variable names sit in registers and are compared against all three request
// names in parallel; values live in a one-port-read, one-port-write RAM with
// a registered read. Lookups only consider defined entries, earliest first.
// Before the result register raises m_tvalid, a define (also on a full table)
// passes S_LOOK and S_FIN, and an unknown name S_LOOK, S_ENC and S_FIN. Add,
// subtract, read and compare pass these steps: name match, priority encode and
// first read, second read, then execute with write back (none for read). One
// operation is worked on at a time and s_tready returns in the cycle after the
// result is loaded.
// The result sits in an output register; if the receiver stalls, a finished
// operation waits in its last state and the next input is not taken until
// the output register frees up.
// Reset empties the table (defined count goes to zero), drops m_tvalid and
// holds s_tready low.
module named_int_variable_store #(
  parameter int MAX_VARS = nivs_pkg::MAX_VARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [2:0] req_type, [10:3] name_a, [18:11] name_b, [26:19] name_c,
  // [58:27] operand_value, [63:59] zero
  input  logic [nivs_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] read_value, [32] is_zero, [34:33] error_code, [39:35] zero
  output logic [nivs_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = $clog2(MAX_VARS);
  localparam int CNT_W = $clog2(MAX_VARS + 1);
  localparam int NW    = nivs_pkg::NAME_W;
  localparam int VW    = nivs_pkg::VALUE_W;

  nivs_pkg::state_t state, state_next;

  // Captured request.
  nivs_pkg::op_t     op;
  logic [NW-1:0]     na, nb, nc;
  logic [VW-1:0]     opv;

  logic [NW-1:0]     name_regs [MAX_VARS];
  logic [CNT_W-1:0]  count;
  logic              full;

  logic [MAX_VARS-1:0] ma, mb, mc;
  logic [IDX_W-1:0]    enc_a, enc_b, enc_c;
  logic [IDX_W-1:0]    ia, ib, ic;
  logic                fa, fb, fc;

  logic [VW-1:0]     va;
  nivs_pkg::err_t    err;

  logic              out_free;
  logic              accept;
  logic              def_write;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VW-1:0]     ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VW-1:0]     ram_rdata;
  logic              load_out;
  logic [VW-1:0]     res_value;
  logic              cmp_res;
  logic              is_arith;

  logic [VW-1:0]     read_value;
  logic              is_zero;
  nivs_pkg::err_t    error_code;

  assign full     = (count == CNT_W'(MAX_VARS));
  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_arith = (op == nivs_pkg::OP_ADD) || (op == nivs_pkg::OP_SUB) ||
                    (op == nivs_pkg::OP_READ);

  assign fa = |ma;
  assign fb = |mb;
  assign fc = |mc;

  // First match wins: scan from the top so the lowest index is left last.
  always_comb begin
    enc_a = '0;
    enc_b = '0;
    enc_c = '0;
    for (int i = MAX_VARS - 1; i >= 0; i--) begin
      if (ma[i]) enc_a = IDX_W'(i);
      if (mb[i]) enc_b = IDX_W'(i);
      if (mc[i]) enc_c = IDX_W'(i);
    end
  end

  always_comb begin
    case (op)
      nivs_pkg::OP_EQ: cmp_res = (va == ram_rdata);
      nivs_pkg::OP_GT: cmp_res = ($signed(va) > $signed(ram_rdata));
      nivs_pkg::OP_LT: cmp_res = ($signed(va) < $signed(ram_rdata));
      nivs_pkg::OP_NE: cmp_res = (va != ram_rdata);
      default:         cmp_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nivs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    def_write  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ia;
    ram_wdata  = '0;
    ram_raddr  = ib;
    load_out   = 1'b0;
    res_value  = '0;
    case (state)
      nivs_pkg::S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) state_next = nivs_pkg::S_LOOK;
      end
      nivs_pkg::S_LOOK: begin
        if (op == nivs_pkg::OP_DEFINE) begin
          if (!full) begin
            def_write = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = count[IDX_W-1:0];
            ram_wdata = opv;
          end
          state_next = nivs_pkg::S_FIN;
        end else begin
          state_next = nivs_pkg::S_ENC;
        end
      end
      nivs_pkg::S_ENC: begin
        ram_raddr = enc_a;
        if (is_arith ? !fa : !(fa && fb && fc)) begin
          state_next = nivs_pkg::S_FIN;
        end else begin
          state_next = nivs_pkg::S_RDB;
        end
      end
      nivs_pkg::S_RDB: begin
        state_next = nivs_pkg::S_EXEC;
      end
      nivs_pkg::S_EXEC: begin
        // The read address stays on ib, so the second operand holds while stalled.
        if (out_free) begin
          load_out   = 1'b1;
          state_next = nivs_pkg::S_IDLE;
          case (op)
            nivs_pkg::OP_ADD: begin
              ram_we    = 1'b1;
              ram_wdata = va + opv;
            end
            nivs_pkg::OP_SUB: begin
              ram_we    = 1'b1;
              ram_wdata = va - opv;
            end
            nivs_pkg::OP_READ: begin
              res_value = va;
            end
            default: begin
              ram_we    = 1'b1;
              ram_waddr = ic;
              ram_wdata = {{(VW-1){1'b0}}, cmp_res};
            end
          endcase
        end
      end
      nivs_pkg::S_FIN: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = nivs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = nivs_pkg::S_IDLE;
      end
    endcase
  end

  // Request capture, lookup and operand registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= nivs_pkg::op_t'(s_tdata[2:0]);
      na  <= s_tdata[10:3];
      nb  <= s_tdata[18:11];
      nc  <= s_tdata[26:19];
      opv <= s_tdata[58:27];
      err <= nivs_pkg::ERR_OK;
    end
    if (state == nivs_pkg::S_LOOK) begin
      for (int i = 0; i < MAX_VARS; i++) begin
        ma[i] <= (name_regs[i] == na) && (CNT_W'(i) < count);
        mb[i] <= (name_regs[i] == nb) && (CNT_W'(i) < count);
        mc[i] <= (name_regs[i] == nc) && (CNT_W'(i) < count);
      end
      if (op == nivs_pkg::OP_DEFINE && full) err <= nivs_pkg::ERR_FULL;
    end
    if (state == nivs_pkg::S_ENC) begin
      ia <= enc_a;
      ib <= enc_b;
      ic <= enc_c;
      if (is_arith ? !fa : !(fa && fb && fc)) err <= nivs_pkg::ERR_UNKNOWN;
    end
    if (state == nivs_pkg::S_RDB) begin
      va <= ram_rdata;
    end
    if (def_write) begin
      name_regs[count[IDX_W-1:0]] <= na;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (def_write) begin
      count <= count + CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_value <= res_value;
      is_zero    <= (op == nivs_pkg::OP_READ) && (err == nivs_pkg::ERR_OK) &&
                    (res_value == '0);
      error_code <= err;
    end
  end

  assign m_tdata = {5'd0, error_code, is_zero, read_value};

  nivs_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_VARS)
  ) u_value_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_VARS))
    else $error("defined count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == nivs_pkg::S_LOOK || state == nivs_pkg::S_EXEC))
    else $error("value RAM written outside define or execute");

  assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(state) == nivs_pkg::S_LOOK &&
                                 $past(op) == nivs_pkg::OP_DEFINE))
    else $error("defined count changed without a define");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((error_code == nivs_pkg::ERR_OK ||
                   error_code == nivs_pkg::ERR_UNKNOWN ||
                   error_code == nivs_pkg::ERR_FULL) &&
                  (!is_zero || read_value == '0)))
    else $error("inconsistent result fields");

  assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result loaded over an untaken result");

endmodule

/* rtl/nivs_ram.sv */
module nivs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
